/* src/atdf_pkg.sv */
// Package for the three-digit autorange formatter.
// Holds the range codes, the scaling constants and the digit codes.
// No dependencies.
package atdf_pkg;

    // Widths of the request and result fields.
    localparam int VALUE_W = 32;
    localparam int DP_W    = 2;
    localparam int DIGIT_W = 4;
    localparam int SHOWN_W = 10;

    // Only the low bits of the value reach the multiplier; anything wider saturates.
    localparam int MUL_IN_W    = 20;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = MUL_IN_W + RECIP_W;

    // Limits of the shown value and the range bounds.
    localparam logic [SHOWN_W-1:0] MAX_SHOWN   = 10'd999;
    localparam logic [VALUE_W-1:0] LIM_UNIT    = 32'd999;
    localparam logic [VALUE_W-1:0] LIM_TENS    = 32'd9999;
    localparam logic [VALUE_W-1:0] LIM_HUND    = 32'd99999;
    localparam logic [VALUE_W-1:0] LIM_THOU    = 32'd999999;

    // Reciprocals for truncating division by 10, 100 and 1000, with their shifts.
    localparam logic [RECIP_W-1:0] RECIP_UNIT  = 21'd1;
    localparam logic [RECIP_W-1:0] RECIP_TENS  = 21'd104858;
    localparam logic [RECIP_W-1:0] RECIP_HUND  = 21'd167773;
    localparam logic [RECIP_W-1:0] RECIP_THOU  = 21'd1073742;
    localparam int                 SHIFT_TENS  = 20;
    localparam int                 SHIFT_HUND  = 24;
    localparam int                 SHIFT_THOU  = 30;

    // Digit code for a blanked position.
    localparam logic [DIGIT_W-1:0] BLANK_CODE  = 4'd10;

    // Point positions.
    localparam logic [DP_W-1:0] DP_NONE   = 2'd0;
    localparam logic [DP_W-1:0] DP_LEFT   = 2'd1;
    localparam logic [DP_W-1:0] DP_MIDDLE = 2'd2;
    localparam logic [DP_W-1:0] DP_RIGHT  = 2'd3;

    // Scale picked for a request.
    typedef enum logic [1:0] {
        RNG_UNIT = 2'd0,
        RNG_TENS = 2'd1,
        RNG_HUND = 2'd2,
        RNG_THOU = 2'd3
    } t_range;

endpackage

/* src/atdf_in_if.sv */
// Request channel of the formatter: the value and the point controls.
// Depends on atdf_pkg.
interface atdf_in_if;
    logic                          valid;
    logic                          ready;
    logic [atdf_pkg::VALUE_W-1:0]  value;
    logic                          autorange;
    logic [atdf_pkg::DP_W-1:0]     fixed_point_pos;

    modport source (output valid, value, autorange, fixed_point_pos, input ready);
    modport sink   (input valid, value, autorange, fixed_point_pos, output ready);
endinterface

/* src/atdf_mid_if.sv */
// Internal channel between the scaling and the digit stages.
// Depends on atdf_pkg.
interface atdf_mid_if;
    logic                          valid;
    logic                          ready;
    logic [atdf_pkg::SHOWN_W-1:0]  shown;
    logic [atdf_pkg::DP_W-1:0]     point_pos;

    modport source (output valid, shown, point_pos, input ready);
    modport sink   (input valid, shown, point_pos, output ready);
endinterface

/* src/atdf_out_if.sv */
// Result channel of the formatter: three digit codes and the point position.
// Depends on atdf_pkg.
interface atdf_out_if;
    logic                          valid;
    logic                          ready;
    logic [atdf_pkg::DIGIT_W-1:0]  left_digit;
    logic [atdf_pkg::DIGIT_W-1:0]  middle_digit;
    logic [atdf_pkg::DIGIT_W-1:0]  right_digit;
    logic [atdf_pkg::DP_W-1:0]     point_pos;

    modport source (output valid, left_digit, middle_digit, right_digit, point_pos,
                    input ready);
    modport sink   (input valid, left_digit, middle_digit, right_digit, point_pos,
                    output ready);
endinterface

/* src/atdf_scale.sv */
// Scaling pipeline: range choice, reciprocal multiply, shift and saturation.
// Depends on atdf_pkg, atdf_in_if and atdf_mid_if.
module atdf_scale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atdf_in_if.sink     i_in,
    atdf_mid_if.source  o_mid
);
    import atdf_pkg::*;

    // Stage valid bits and the ready chain.
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3     = !r_v3 || o_mid.ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    // Stage one: pick the range, the point and whether the result saturates.
    t_range                 n_rng, r1_rng, r2_rng;
    logic                   n_sat, r1_sat, r2_sat;
    logic [DP_W-1:0]        n_dp, r1_dp, r2_dp, r3_dp;
    logic [MUL_IN_W-1:0]    r1_val;

    always_comb begin
        n_rng = RNG_UNIT;
        n_sat = 1'b0;
        n_dp  = DP_NONE;
        if (i_in.autorange) begin
            if (i_in.value <= LIM_UNIT) begin
                n_rng = RNG_UNIT;
                n_dp  = DP_NONE;
            end else if (i_in.value <= LIM_TENS) begin
                n_rng = RNG_TENS;
                n_dp  = DP_LEFT;
            end else if (i_in.value <= LIM_HUND) begin
                n_rng = RNG_HUND;
                n_dp  = DP_MIDDLE;
            end else begin
                n_rng = RNG_THOU;
                n_dp  = DP_RIGHT;
                n_sat = (i_in.value > LIM_THOU);
            end
        end else begin
            n_rng = RNG_UNIT;
            n_dp  = i_in.fixed_point_pos;
            n_sat = (i_in.value > LIM_UNIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_in.valid;
        end
        if (w_rdy1 && i_in.valid) begin
            r1_rng <= n_rng;
            r1_sat <= n_sat;
            r1_dp  <= n_dp;
            r1_val <= i_in.value[MUL_IN_W-1:0];
        end
    end

    // Stage two: multiply by the reciprocal of the divisor.
    logic [RECIP_W-1:0] w_recip;
    logic [PROD_W-1:0]  n_prod, r2_prod;

    always_comb begin
        unique case (r1_rng)
            RNG_UNIT: w_recip = RECIP_UNIT;
            RNG_TENS: w_recip = RECIP_TENS;
            RNG_HUND: w_recip = RECIP_HUND;
            RNG_THOU: w_recip = RECIP_THOU;
            default:  w_recip = RECIP_UNIT;
        endcase
    end

    assign n_prod = PROD_W'(r1_val) * PROD_W'(w_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2 && r_v1) begin
            r2_rng  <= r1_rng;
            r2_sat  <= r1_sat;
            r2_dp   <= r1_dp;
            r2_prod <= n_prod;
        end
    end

    // Stage three: drop the fraction and clamp to the display range.
    logic [PROD_W-1:0]  w_quot;
    logic [SHOWN_W-1:0] n_shown, r3_shown;

    always_comb begin
        unique case (r2_rng)
            RNG_UNIT: w_quot = r2_prod;
            RNG_TENS: w_quot = r2_prod >> SHIFT_TENS;
            RNG_HUND: w_quot = r2_prod >> SHIFT_HUND;
            RNG_THOU: w_quot = r2_prod >> SHIFT_THOU;
            default:  w_quot = r2_prod;
        endcase
        n_shown = r2_sat ? MAX_SHOWN : w_quot[SHOWN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
        if (w_rdy3 && r_v2) begin
            r3_shown <= n_shown;
            r3_dp    <= r2_dp;
        end
    end

    assign o_mid.valid     = r_v3;
    assign o_mid.shown     = r3_shown;
    assign o_mid.point_pos = r3_dp;

`ifndef SYNTH
    // A shown value never exceeds the display limit.
    a_shown_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r3_shown <= MAX_SHOWN))
        else $error("shown value above display limit");

    // A stalled last stage keeps its request.
    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !o_mid.ready) |=> (r_v3 && $stable(r3_shown) && $stable(r3_dp)))
        else $error("stalled scaling stage changed");

    // The thousands range always carries the point on the right digit.
    a_thou_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r2_rng == RNG_THOU) |-> (r2_dp == DP_RIGHT))
        else $error("thousands range without right point");
`endif

endmodule

/* src/atdf_digits.sv */
// Digit pipeline: splits the shown value into decimal digits and blanks leading zeros.
// Depends on atdf_pkg, atdf_mid_if and atdf_out_if.
module atdf_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atdf_mid_if.sink    i_mid,
    atdf_out_if.source  o_out
);
    import atdf_pkg::*;

    // Stage valid bits and the ready chain.
    logic r_v4, r_v5;
    logic w_rdy4, w_rdy5;

    assign w_rdy5      = !r_v5 || o_out.ready;
    assign w_rdy4      = !r_v4 || w_rdy5;
    assign i_mid.ready = w_rdy4;

    // Stage four: hundreds digit and value divided by ten, both by reciprocal.
    logic [15:0]          w_mul41;
    logic [17:0]          w_mul205;
    logic [DIGIT_W-1:0]   r4_d0;
    logic [6:0]           r4_q10;
    logic [SHOWN_W-1:0]   r4_shown;
    logic [DP_W-1:0]      r4_dp;

    assign w_mul41  = 16'(i_mid.shown) * 16'd41;
    assign w_mul205 = 18'(i_mid.shown) * 18'd205;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= i_mid.valid;
        end
        if (w_rdy4 && i_mid.valid) begin
            r4_d0    <= w_mul41[15:12];
            r4_q10   <= w_mul205[17:11];
            r4_shown <= i_mid.shown;
            r4_dp    <= i_mid.point_pos;
        end
    end

    // Stage five: tens and units by subtraction, then leading-zero blanking.
    logic [6:0]         w_d1_full;
    logic [SHOWN_W-1:0] w_d2_full;
    logic [DIGIT_W-1:0] w_d1, w_d2;
    logic               w_show0, w_show1;
    logic [DIGIT_W-1:0] r5_left, r5_middle, r5_right;
    logic [DP_W-1:0]    r5_dp;

    always_comb begin
        w_d1_full = r4_q10 - (7'(r4_d0) * 7'd10);
        w_d2_full = r4_shown - (10'(r4_q10) * 10'd10);
        w_d1      = w_d1_full[DIGIT_W-1:0];
        w_d2      = w_d2_full[DIGIT_W-1:0];
        w_show0   = (r4_d0 != '0) || (r4_dp == DP_LEFT);
        w_show1   = (w_d1 != '0) || (r4_dp == DP_MIDDLE) || w_show0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= r_v4;
        end
        if (w_rdy5 && r_v4) begin
            r5_left   <= w_show0 ? r4_d0 : BLANK_CODE;
            r5_middle <= w_show1 ? w_d1 : BLANK_CODE;
            r5_right  <= w_d2;
            r5_dp     <= r4_dp;
        end
    end

    assign o_out.valid        = r_v5;
    assign o_out.left_digit   = r5_left;
    assign o_out.middle_digit = r5_middle;
    assign o_out.right_digit  = r5_right;
    assign o_out.point_pos    = r5_dp;

`ifndef SYNTH
    // The right digit is always a decimal digit.
    a_right_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r5_right <= 4'd9))
        else $error("right digit out of range");

    // A shown left digit forces the middle digit to be shown.
    a_blank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r5_left != BLANK_CODE) |-> (r5_middle != BLANK_CODE))
        else $error("middle digit blanked after a shown left digit");

    // A point on the left digit keeps that digit lit.
    a_left_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r5_dp == DP_LEFT) |-> (r5_left != BLANK_CODE))
        else $error("left digit blanked under its point");
`endif

endmodule

/* src/autorange_three_digit_formatter.sv */
// Channel    Dir  Contents
// i_in       in   value[31:0], autorange, fixed_point_pos[1:0]
// o_out      out  left_digit[3:0], middle_digit[3:0], right_digit[3:0], point_pos[1:0]
//
// Five register stages; one request is taken per cycle while o_out does not stall.
// Synchronous active-low reset clears the stage valid bits only.
// A stall on o_out holds each full stage in place; an empty stage still fills.
// Top level: the scaling pipeline followed by the digit pipeline.
// Depends on atdf_pkg, the channel interfaces, atdf_scale and atdf_digits.
module autorange_three_digit_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atdf_in_if.sink     i_in,
    atdf_out_if.source  o_out
);
    import atdf_pkg::*;

    // Channel between the two halves of the pipeline.
    atdf_mid_if u_mid ();

    atdf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_mid   (u_mid.source)
    );

    atdf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mid   (u_mid.sink),
        .o_out   (o_out)
    );

endmodule
